// ----- rtl/xsp_pkg.sv -----
package xsp_pkg;

  // input kinds
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_QUEUE = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_OPEN  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_PRESENT    = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  // stripe conditions
  localparam logic [1:0] COND_UNPROTECTED = 2'd0;
  localparam logic [1:0] COND_QUEUED      = 2'd1;
  localparam logic [1:0] COND_PROTECTED   = 2'd2;

  // configuration register indexes
  localparam logic CFG_MEMBER_COUNT = 1'b0;
  localparam logic CFG_PAGE_LEN     = 1'b1;

  localparam int MAP_W = 16;

  typedef enum logic [2:0] {
    OP_DATA,
    OP_READ,
    OP_QUEUE,
    OP_DONE,
    OP_OPEN,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [3:0]       slot;
    logic [11:0]      offset;
    logic [7:0]       data;
    logic             ok;
    logic             last;
    logic [MAP_W-1:0] mask;
  } cmd_t;

endpackage

// ----- rtl/xsp_front.sv -----
module xsp_front #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_MEMBERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data,
  input  logic [2:0]    in_kind,
  input  logic [7:0]    in_slot,
  input  logic [11:0]   in_offset,
  input  logic [7:0]    in_data_byte,
  input  logic [15:0]   in_length,
  input  logic          in_ok,
  output xsp_pkg::cmd_t cmd
);
  import xsp_pkg::*;

  localparam logic [16:0] PAGE_LIM  = 17'(PAGE_BYTES);
  localparam logic [4:0]  COUNT_LIM = 5'(MAX_MEMBERS);

  logic [4:0]  member_count_r;
  logic [12:0] page_len_r;

  logic        count_ok;
  logic        page_ok;
  logic        data_ok;
  logic        read_ok;
  logic [16:0] one_hot;
  logic [16:0] mask_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_count_r <= 5'd1;
      page_len_r     <= 13'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEMBER_COUNT: member_count_r <= cfg_data[4:0];
        CFG_PAGE_LEN:     page_len_r     <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    count_ok = (member_count_r != 5'd0) && (member_count_r <= COUNT_LIM);
    page_ok  = (page_len_r != 13'd0) && ({4'b0, page_len_r} <= PAGE_LIM);
    data_ok  = count_ok && page_ok
            && ({1'b0, in_slot} < {4'b0, member_count_r})
            && (in_length == {3'b0, page_len_r})
            && ({1'b0, in_offset} < page_len_r);
    read_ok  = ({5'b0, in_offset} < PAGE_LIM);
    one_hot  = 17'd1 << member_count_r;
    mask_w   = one_hot - 17'd1;

    cmd.slot   = in_slot[3:0];
    cmd.offset = in_offset;
    cmd.data   = in_data_byte;
    cmd.ok     = in_ok;
    cmd.last   = ({1'b0, in_offset} == (page_len_r - 13'd1));
    cmd.mask   = mask_w[MAP_W-1:0];

    unique case (in_kind)
      KIND_DATA:  cmd.op = data_ok ? OP_DATA : OP_REJECT;
      KIND_READ:  cmd.op = read_ok ? OP_READ : OP_REJECT;
      KIND_QUEUE: cmd.op = count_ok ? OP_QUEUE : OP_REJECT;
      KIND_DONE:  cmd.op = OP_DONE;
      KIND_OPEN:  cmd.op = OP_OPEN;
      default:    cmd.op = OP_REJECT;
    endcase
  end

endmodule

// ----- rtl/xsp_cmdq.sv -----
module xsp_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xsp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output xsp_pkg::cmd_t head,
  output logic          empty
);
  import xsp_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/xsp_back.sv -----
module xsp_back #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  xsp_pkg::cmd_t cmd_head,
  output logic          cmd_pop,
  output logic          boot,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_status,
  output logic [1:0]    out_stripe_state,
  output logic [7:0]    out_parity_byte,
  output logic [15:0]   out_members_present
);
  import xsp_pkg::*;

  localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_BYTES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t           state_r;
  cmd_t             cur_r;
  logic [MAP_W-1:0] map_r;
  logic [1:0]       cond_r;
  logic [AW-1:0]    clr_r;
  logic             boot_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [1:0]       out_state_r;
  logic [7:0]       out_parity_r;
  logic [MAP_W-1:0] out_map_r;

  logic [7:0]       mem [PAGE_BYTES];
  logic [7:0]       rdata_r;

  logic [16:0]      head_off;
  logic [16:0]      cur_off;
  logic [AW-1:0]    rd_addr;
  logic             out_free;
  logic             exec_fire;
  logic             dup;
  logic [MAP_W-1:0] slot_bit;
  logic [1:0]       res_status;
  logic [7:0]       res_parity;
  logic [MAP_W-1:0] map_nxt;
  logic [1:0]       cond_nxt;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [7:0]       mem_wd;

  assign out_empty           = !out_valid_r;
  assign out_status          = out_status_r;
  assign out_stripe_state    = out_state_r;
  assign out_parity_byte     = out_parity_r;
  assign out_members_present = out_map_r;
  assign boot                = boot_r;

  always_comb begin
    head_off  = {5'b0, cmd_head.offset};
    cur_off   = {5'b0, cur_r.offset};
    rd_addr   = (state_r == S_IDLE) ? head_off[AW-1:0] : cur_off[AW-1:0];
    out_free  = !out_valid_r || out_pop;
    exec_fire = (state_r == S_EXEC) && out_free;
    cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
    slot_bit  = MAP_W'(1) << cur_r.slot;
    dup       = |(map_r & slot_bit);

    res_status = ST_OK;
    res_parity = 8'd0;
    map_nxt    = map_r;
    cond_nxt   = cond_r;
    mem_we     = 1'b0;
    mem_wa     = cur_off[AW-1:0];
    mem_wd     = rdata_r ^ cur_r.data;

    unique case (cur_r.op)
      OP_DATA: begin
        if (dup) begin
          res_status = ST_PRESENT;
        end else begin
          mem_we   = exec_fire;
          cond_nxt = COND_UNPROTECTED;
          if (cur_r.last) map_nxt = map_r | slot_bit;
        end
      end
      OP_READ:  res_parity = rdata_r;
      OP_QUEUE: begin
        if (map_r != cur_r.mask) res_status = ST_INCOMPLETE;
        else                     cond_nxt   = COND_QUEUED;
      end
      OP_DONE: begin
        if (cond_r == COND_QUEUED) begin
          cond_nxt = cur_r.ok ? COND_PROTECTED : COND_UNPROTECTED;
        end
      end
      OP_OPEN: begin
        map_nxt  = '0;
        cond_nxt = COND_UNPROTECTED;
      end
      default: res_status = ST_INVALID;
    endcase

    // the clearing sweep owns the write port
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      boot_r      <= 1'b1;
      map_r       <= '0;
      cond_r      <= COND_UNPROTECTED;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && !exec_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
            boot_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cur_r   <= cmd_head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the result register is free
          if (out_free) begin
            map_r        <= map_nxt;
            cond_r       <= cond_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_state_r  <= cond_nxt;
            out_parity_r <= res_parity;
            out_map_r    <= map_nxt;
            clr_r        <= '0;
            state_r      <= (cur_r.op == OP_OPEN) ? S_CLEAR : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/xor_stripe_parity_tracker_top.sv -----
// Channel  Handshake              Payload
// in       in_push / in_full      kind, slot, offset, data_byte, length, ok
// out      out_pop / out_empty    status, stripe_state, parity_byte, members_present
// cfg      cfg_valid / cfg_ready  cfg_index (0 member_count, 1 page length), cfg_data
//
// In the back end an item first reads the parity memory, then writes it back and
// registers the result. A two-entry command queue lets the front keep taking
// items while the back end works or waits for out_pop.
// After reset a sweep zeroes the parity memory, with in_full held high. An open
// item starts the same sweep; items queue behind it.
module xor_stripe_parity_tracker_top #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_MEMBERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_slot,
  input  logic [11:0] in_offset,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_length,
  input  logic        in_ok,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [1:0]  out_stripe_state,
  output logic [7:0]  out_parity_byte,
  output logic [15:0] out_members_present,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import xsp_pkg::*;

  cmd_t new_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic boot;

  assign in_full = q_full || boot;

  xsp_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (in_kind),
    .in_slot      (in_slot),
    .in_offset    (in_offset),
    .in_data_byte (in_data_byte),
    .in_length    (in_length),
    .in_ok        (in_ok),
    .cmd          (new_cmd)
  );

  xsp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push && !in_full),
    .push_cmd (new_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_cmd),
    .empty    (q_empty)
  );

  xsp_back #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_empty           (q_empty),
    .cmd_head            (head_cmd),
    .cmd_pop             (q_pop),
    .boot                (boot),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_stripe_state    (out_stripe_state),
    .out_parity_byte     (out_parity_byte),
    .out_members_present (out_members_present)
  );

`ifndef ASSERT_OFF
  a_no_result_in_boot: assert property (@(posedge clk) disable iff (!rst_n)
    boot |-> out_empty)
    else $error("result presented before parity memory was cleared");

  a_present_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_PRESENT) |-> (out_members_present != 16'd0))
    else $error("slot reported present with empty member map");

  a_parity_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_parity_byte != 8'd0) |-> (out_status == ST_OK))
    else $error("parity byte returned with failing status");
`endif

endmodule
